@@ rtl/core/rrqs_pkg.sv @@
package rrqs_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TIME_BITS   = 16;

  localparam int IDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int TOTAL_W    = TIME_BITS + IDX_W;
  localparam int DIVIDEND_W = TOTAL_W + 7;
  localparam int CMP_W      = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_IDX_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_SERVE  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_IGNORED  = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_DONE     = 3'd3;
  localparam logic [2:0] ST_REQUEUED = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;
  localparam logic [2:0] ST_AVERAGE  = 3'd6;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SERVE,
    OP_FINISH,
    OP_IGNORE
  } op_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] job_time;
    logic [15:0] quantum;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] served_time;
    logic [22:0] average_hundredths;
    logic        queue_was_empty;
  } out_item_t;

  typedef struct packed {
    op_e                  op;
    logic [TIME_BITS-1:0] job_time;
    logic [15:0]          quantum;
  } cmd_t;

  typedef struct packed {
    logic       busy;
    logic [CNT_W-1:0] job_count;
  } back_stat_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    next_idx = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

endpackage

@@ rtl/core/rrqs_front.sv @@
module rrqs_front import rrqs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t                  entry_q [CMDQ_DEPTH];
  logic [CMDQ_IDX_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] fill_q, fill_d;
  cmd_t                  cmd_in;
  logic                  do_push, do_pop;

  // classify: zero-time add and unknown kind collapse to ignore
  always_comb begin
    cmd_in.job_time = TIME_BITS'(item_i.job_time);
    cmd_in.quantum  = item_i.quantum;
    case (item_i.kind)
      KIND_ADD:    cmd_in.op = (cmd_in.job_time == '0) ? OP_IGNORE : OP_ADD;
      KIND_SERVE:  cmd_in.op = OP_SERVE;
      KIND_FINISH: cmd_in.op = OP_FINISH;
      default:     cmd_in.op = OP_IGNORE;
    endcase
  end

  assign full_o      = (fill_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + CMDQ_IDX_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + CMDQ_IDX_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + CMDQ_CNT_W'(1);
      2'b01:   fill_d = fill_q - CMDQ_CNT_W'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

@@ rtl/core/rrqs_div.sv @@
module rrqs_div import rrqs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]      divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  logic                  busy_q, busy_d, done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]      rem_q, rem_d, div_q, div_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [CNT_W:0]        trial;
  logic                  take;

  // restoring division, one quotient bit a cycle; quo_q shifts dividend out, quotient in
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign take  = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIVIDEND_W);
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = take ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
      quo_d = {quo_q[DIVIDEND_W-2:0], take};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/core/rrqs_back.sv @@
module rrqs_back import rrqs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       res_valid_o,
  output out_item_t  res_o,
  input  logic       res_pop_i,
  output back_stat_t stat_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SERVE = 3'b010,
    S_DIV   = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [TIME_BITS-1:0]  mem [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]  rd_data_q, wr_data;
  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [TOTAL_W-1:0]    total_q, total_d;
  logic                  res_valid_q, res_valid_d;
  out_item_t             res_q, res_d;
  logic                  div_start, div_done;
  logic [DIVIDEND_W-1:0] dividend, quotient;
  logic [CMP_W-1:0]      t_ext, q_ext;

  assign t_ext    = CMP_W'(rd_data_q);
  assign q_ext    = CMP_W'(cmd_i.quantum);
  // 100*sum + n/2, so the truncating divide rounds to nearest
  assign dividend = DIVIDEND_W'(total_q) * DIVIDEND_W'(100) + DIVIDEND_W'(count_q >> 1);

  rrqs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    total_d     = total_q;
    res_valid_d = res_valid_q && !res_pop_i;
    res_d       = res_q;
    cmd_pop_o   = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_data     = cmd_i.job_time;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !res_valid_q) begin
          res_d = '0;
          case (cmd_i.op)
            OP_ADD: begin
              cmd_pop_o   = 1'b1;
              res_valid_d = 1'b1;
              if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                res_d.status = ST_DROPPED;
              end else begin
                wr_en        = 1'b1;
                tail_d       = next_idx(tail_q);
                count_d      = count_q + CNT_W'(1);
                total_d      = total_q + TOTAL_W'(cmd_i.job_time);
                res_d.status = ST_ADDED;
              end
            end
            OP_SERVE: begin
              if (count_q == '0) begin
                cmd_pop_o    = 1'b1;
                res_valid_d  = 1'b1;
                res_d.status = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                state_d = S_SERVE;
              end
            end
            OP_FINISH: begin
              if (count_q == '0) begin
                cmd_pop_o             = 1'b1;
                res_valid_d           = 1'b1;
                res_d.status          = ST_AVERAGE;
                res_d.queue_was_empty = 1'b1;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
              total_d = '0;
            end
            default: begin
              cmd_pop_o    = 1'b1;
              res_valid_d  = 1'b1;
              res_d.status = ST_IGNORED;
            end
          endcase
        end
      end
      S_SERVE: begin
        // head entry read last cycle; a requeue may write the same slot when full
        cmd_pop_o   = 1'b1;
        res_valid_d = 1'b1;
        res_d       = '0;
        head_d      = next_idx(head_q);
        if (t_ext > q_ext) begin
          wr_en             = 1'b1;
          wr_data           = TIME_BITS'(t_ext - q_ext);
          tail_d            = next_idx(tail_q);
          total_d           = total_q - TOTAL_W'(q_ext);
          res_d.status      = ST_REQUEUED;
          res_d.served_time = cmd_i.quantum;
        end else begin
          count_d           = count_q - CNT_W'(1);
          total_d           = total_q - TOTAL_W'(rd_data_q);
          res_d.status      = ST_DONE;
          res_d.served_time = 16'(rd_data_q);
        end
        state_d = S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          cmd_pop_o                = 1'b1;
          res_valid_d              = 1'b1;
          res_d                    = '0;
          res_d.status             = ST_AVERAGE;
          res_d.average_hundredths = 23'(quotient);
          state_d                  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (wr_en) begin
      mem[tail_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[head_q];
    end
  end

  assign res_valid_o      = res_valid_q;
  assign res_o            = res_q;
  assign stat_o.busy      = (state_q != S_IDLE);
  assign stat_o.job_count = count_q;

endmodule

@@ rtl/core/round_robin_quantum_scheduler.sv @@
// Round-robin time-quantum scheduler.
// Input channel: push/full with in_item_i (kind, job_time, quantum); a word is
// taken when push is high and full is low. A two-word command queue sits in
// front, so words are taken while the back end is busy or a result waits.
// Result channel: empty/pop with out_item_o; one result word per input word,
// in input order, taken when pop is high and empty is low.
// Add, ignore, empty serve and empty finish register their result directly from
// the command queue head; a serve of a queued job first does a registered read
// of the job memory, then writes back the requeued remainder; a finish on a
// non-empty queue waits for the one-bit-a-cycle divider that forms the rounded
// average. A command starts only after the previous result has left its
// register, so the back end takes no new command while a result waits.
// If pop is held low the result register holds its word, the back end waits,
// and full rises once the command queue has two words.
// Reset empties the job queue, the command queue and the result register;
// job memory contents are left as they are and are never read unwritten.
module round_robin_quantum_scheduler import rrqs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic       cmd_valid, cmd_pop, res_valid;
  cmd_t       cmd;
  back_stat_t stat;

  rrqs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rrqs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (out_item_o),
    .res_pop_i   (pop),
    .stat_o      (stat)
  );

  assign empty = !res_valid;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.job_count <= CNT_W'(QUEUE_DEPTH))
    else $error("job count above queue depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> cmd_valid)
    else $error("accepted word lost from command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.queue_was_empty) |->
      (out_item_o.status == ST_AVERAGE && out_item_o.average_hundredths == '0))
    else $error("empty finish result malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop && stat.busy) |=> !empty)
    else $error("completed command produced no result");

endmodule
